/* rtl/core/ssv_pkg.sv */
package ssv_pkg;

  localparam int unsigned PRES_W  = 16;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  // Internal sample width covers the largest supported SAMPLE_WIDTH.
  localparam int unsigned SMP_W   = 24;
  localparam int unsigned PROD_W  = SMP_W + GAIN_W;
  localparam int unsigned SCALE_W = PROD_W - 16;

  typedef enum logic [1:0] {
    DIAG_OK     = 2'd0,
    DIAG_RAW    = 2'd1,
    DIAG_SCALED = 2'd2,
    DIAG_RATE   = 2'd3
  } diag_t;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENG_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENG_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 3'd5;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_min;
    logic [RAW_W-1:0]  raw_max;
    logic [GAIN_W-1:0] gain;
    logic [PRES_W-1:0] eng_min;
    logic [PRES_W-1:0] eng_max;
    logic [PRES_W-1:0] max_delta;
  } cfg_regs_t;

  // Result of the window checks, handed to the rate check stage.
  typedef struct packed {
    diag_t             diag;
    logic [PRES_W-1:0] value;
  } scale_res_t;

endpackage

/* rtl/core/ssv_scale.sv */
module ssv_scale import ssv_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             valid_in,
  input  logic [RAW_W-1:0] raw_in,
  input  cfg_regs_t        cfg,
  output logic             valid_r,
  output scale_res_t       res_r
);

  localparam logic [SMP_W-1:0] SampleMask = SMP_W'((25'(1) << SAMPLE_WIDTH) - 25'(1));

  logic [SMP_W-1:0]   raw;
  logic [SMP_W-1:0]   rmin;
  logic [SMP_W-1:0]   rmax;
  logic [SMP_W-1:0]   diff;
  logic [PROD_W-1:0]  prod;
  logic [SCALE_W:0]   scaled;
  scale_res_t         res_nxt;

  assign raw  = SMP_W'(raw_in) & SampleMask;
  assign rmin = SMP_W'(cfg.raw_min);
  assign rmax = SMP_W'(cfg.raw_max);
  assign diff = raw - rmin;
  assign prod = PROD_W'(diff) * PROD_W'(cfg.gain);
  // The sum keeps a carry bit so large values never wrap into the window.
  assign scaled = (SCALE_W+1)'(cfg.eng_min) + (SCALE_W+1)'(prod[PROD_W-1:16]);

  always_comb begin
    res_nxt.value = scaled[PRES_W-1:0];
    if (raw < rmin || raw > rmax) begin
      res_nxt.diag = DIAG_RAW;
    end else if (scaled > (SCALE_W+1)'(cfg.eng_max)) begin
      res_nxt.diag = DIAG_SCALED;
    end else begin
      res_nxt.diag = DIAG_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load && valid_in) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* rtl/core/ssv_check.sv */
module ssv_check import ssv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              valid_in,
  input  scale_res_t        res_in,
  input  logic [PRES_W-1:0] max_delta,
  output logic              valid_r,
  output logic [PRES_W-1:0] pressure_r,
  output logic              ok_r,
  output diag_t             diag_r
);

  logic              have_hist_r;
  logic [PRES_W-1:0] last_r;
  logic [PRES_W-1:0] delta;
  diag_t             diag_nxt;
  logic              accept;

  assign delta = (res_in.value >= last_r) ? (res_in.value - last_r)
                                          : (last_r - res_in.value);

  always_comb begin
    diag_nxt = res_in.diag;
    if (res_in.diag == DIAG_OK && have_hist_r && delta > max_delta) begin
      diag_nxt = DIAG_RATE;
    end
  end

  assign accept = load && valid_in && diag_nxt == DIAG_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      have_hist_r <= 1'b0;
      last_r      <= '0;
    end else begin
      if (load) begin
        valid_r <= valid_in;
      end
      // Only an accepted item moves the history; rejected items leave it alone.
      if (accept) begin
        have_hist_r <= 1'b1;
        last_r      <= res_in.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && valid_in) begin
      diag_r     <= diag_nxt;
      ok_r       <= (diag_nxt == DIAG_OK);
      pressure_r <= (diag_nxt == DIAG_OK) ? res_in.value : '0;
    end
  end

endmodule

/* rtl/core/sensor_sample_validator_core.sv */
// Sensor sample validator: each item carries one raw converter count, which is
// checked against the raw window, scaled to 1/64 kPa as
// eng_min + (((raw - raw_min) * gain) >> 16), checked against the engineering
// window and, once a sample has been accepted, against max_delta from the last
// accepted value. Every item yields exactly one result; a rejected item gives
// pressure 0, sample_ok 0 and the failing check in diag_code. Items flow through
// three register stages (input, scaled value, result). The input register loads
// at the accepting edge; the item then moves through the scaled value register
// and the result register; one item is taken every cycle while the output is not
// stalled. The rate history is updated in the result stage, which
// lets each item see the outcome of the one just ahead of it. Configuration
// writes are always ready and take effect at once; write them only while the
// block holds no items.
module sensor_sample_validator_core import ssv_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAW_W-1:0]      in_raw_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PRES_W-1:0]     out_pressure,
  output logic                  out_sample_ok,
  output logic [1:0]            out_diag_code,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t        cfg_r;
  logic             in_v_r;
  logic [RAW_W-1:0] in_raw_r;
  logic             sc_v;
  scale_res_t       sc_res;
  logic             ck_v;
  diag_t            ck_diag;
  logic             ld_in;
  logic             ld_sc;
  logic             ld_ck;

  // A stage may load when it is empty or when the stage after it loads.
  assign ld_ck = !ck_v || !out_stall;
  assign ld_sc = !sc_v || ld_ck;
  assign ld_in = !in_v_r || ld_sc;

  assign in_stall  = !ld_in;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.raw_min   <= 16'd0;
      cfg_r.raw_max   <= 16'd65535;
      cfg_r.gain      <= 24'd64001;
      cfg_r.eng_min   <= 16'd0;
      cfg_r.eng_max   <= 16'd64000;
      cfg_r.max_delta <= 16'd3200;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RAW_MIN:   cfg_r.raw_min   <= cfg_data[RAW_W-1:0];
        CFG_RAW_MAX:   cfg_r.raw_max   <= cfg_data[RAW_W-1:0];
        CFG_GAIN:      cfg_r.gain      <= cfg_data[GAIN_W-1:0];
        CFG_ENG_MIN:   cfg_r.eng_min   <= cfg_data[PRES_W-1:0];
        CFG_ENG_MAX:   cfg_r.eng_max   <= cfg_data[PRES_W-1:0];
        CFG_MAX_DELTA: cfg_r.max_delta <= cfg_data[PRES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (ld_in) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in && in_valid) begin
      in_raw_r <= in_raw_sample;
    end
  end

  ssv_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ld_sc),
    .valid_in (in_v_r),
    .raw_in   (in_raw_r),
    .cfg      (cfg_r),
    .valid_r  (sc_v),
    .res_r    (sc_res)
  );

  ssv_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ld_ck),
    .valid_in   (sc_v),
    .res_in     (sc_res),
    .max_delta  (cfg_r.max_delta),
    .valid_r    (ck_v),
    .pressure_r (out_pressure),
    .ok_r       (out_sample_ok),
    .diag_r     (ck_diag)
  );

  assign out_valid     = ck_v;
  assign out_diag_code = ck_diag;

endmodule
